@@ rtl/chs_pkg.sv @@
// Shared constants, codes and types of the chroma subsampler.
package chs_pkg;

    localparam int CHS_MAX_LINE_WIDTH = 2048;
    localparam int CHS_SAMPLE_BITS    = 8;
    localparam int CHS_CFG_DATA_BITS  = 12;
    localparam int CHS_CMD_DEPTH      = 4;
    localparam int CHS_OUT_DEPTH      = 4;

    localparam logic [CHS_CFG_DATA_BITS-1:0] CHS_LINE_WIDTH_RESET = 12'd1920;

    typedef enum logic {
        CFG_MODE       = 1'b0,
        CFG_LINE_WIDTH = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_AVG_PAIR,
        OP_AVG_BLOCK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic row_end;
    } t_cmd_ctl;

    localparam int CHS_CMD_CTL_BITS = $bits(t_cmd_ctl);

endpackage

@@ rtl/chs_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
module chs_fifo import chs_pkg::*; #(
    parameter int WIDTH = CHS_SAMPLE_BITS,
    parameter int DEPTH = CHS_OUT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_data,
    output logic [$clog2(DEPTH):0]   o_count
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ rtl/chs_front.sv @@
// Front end: configuration registers, row and column tracking, pair sums and command issue.
module chs_front import chs_pkg::*; #(
    parameter int MAX_LINE_WIDTH = CHS_MAX_LINE_WIDTH,
    parameter int SAMPLE_BITS    = CHS_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [0:0]                           i_cfg_index,
    input  logic [CHS_CFG_DATA_BITS-1:0]         i_cfg_data,
    input  logic                                 i_accept,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    input  logic                                 i_frame_start,
    output logic                                 o_cmd_valid,
    output t_cmd_ctl                             o_cmd_ctl,
    output logic [$clog2(MAX_LINE_WIDTH/2)-1:0]  o_cmd_slot,
    output logic [SAMPLE_BITS:0]                 o_cmd_sum
);

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = (CW + 1 > CHS_CFG_DATA_BITS) ? CW + 1 : CHS_CFG_DATA_BITS;
    localparam logic [WW-1:0] MIN_W = WW'(2);
    localparam logic [WW-1:0] MAX_W = WW'(MAX_LINE_WIDTH & ~1);

    logic                          r_mode;
    logic [CHS_CFG_DATA_BITS-1:0]  r_line_width;
    logic [WW-1:0]                 lw_even;
    logic [WW-1:0]                 eff_width;

    logic [CW-1:0]          r_col;
    logic [CW-1:0]          n_col;
    logic                   r_odd_row;
    logic                   n_odd_row;
    logic [SAMPLE_BITS-1:0] r_held;
    logic [CW-1:0]          col_start;
    logic                   row_start;
    logic [CW-1:0]          col;
    logic                   row;
    logic [CW:0]            col_inc;
    logic                   last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_line_width <= CHS_LINE_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MODE:       r_mode       <= i_cfg_data[0];
                CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Effective width: even, at least two, at most the buffer capacity.
    always_comb begin
        lw_even = WW'({r_line_width[CHS_CFG_DATA_BITS-1:1], 1'b0});
        priority if (lw_even < MIN_W) begin
            eff_width = MIN_W;
        end else if (lw_even > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = lw_even;
        end
    end

    always_comb begin
        col_start = i_frame_start ? '0 : r_col;
        row_start = i_frame_start ? 1'b0 : r_odd_row;
        // A width lowered mid-row closes the row before this sample.
        if (WW'(col_start) >= eff_width) begin
            col = '0;
            row = ~row_start;
        end else begin
            col = col_start;
            row = row_start;
        end
        col_inc   = {1'b0, col} + (CW+1)'(1);
        last      = WW'(col_inc) >= eff_width;
        n_col     = last ? '0 : col_inc[CW-1:0];
        n_odd_row = last ? ~row : row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_odd_row <= 1'b0;
            r_held    <= '0;
        end else if (i_accept) begin
            r_col     <= n_col;
            r_odd_row <= n_odd_row;
            if (!col[0]) begin
                r_held <= i_sample;
            end
        end
    end

    always_comb begin
        o_cmd_valid       = i_accept && col[0];
        o_cmd_sum         = {1'b0, r_held} + {1'b0, i_sample};
        o_cmd_slot        = col[CW-1:1];
        o_cmd_ctl.row_end = last;
        if (!r_mode) begin
            o_cmd_ctl.op = OP_AVG_PAIR;
        end else if (row) begin
            o_cmd_ctl.op = OP_AVG_BLOCK;
        end else begin
            o_cmd_ctl.op = OP_WRITE;
        end
    end

endmodule

@@ rtl/chs_back.sv @@
// Back end: line buffer, block and pair averaging, result issue with output credit.
module chs_back import chs_pkg::*; #(
    parameter int MAX_LINE_WIDTH = CHS_MAX_LINE_WIDTH,
    parameter int SAMPLE_BITS    = CHS_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  t_cmd_ctl                             i_cmd_ctl,
    input  logic [$clog2(MAX_LINE_WIDTH/2)-1:0]  i_cmd_slot,
    input  logic [SAMPLE_BITS:0]                 i_cmd_sum,
    output logic                                 o_cmd_pop,
    input  logic [$clog2(CHS_OUT_DEPTH):0]       i_out_count,
    output logic                                 o_res_valid,
    output logic [SAMPLE_BITS-1:0]               o_avg_value,
    output logic                                 o_row_end
);

    localparam int PAIRS = MAX_LINE_WIDTH / 2;
    localparam int OCW   = $clog2(CHS_OUT_DEPTH) + 1;

    logic [SAMPLE_BITS:0]   r_line [PAIRS];
    logic [SAMPLE_BITS:0]   r_rd_data;
    logic                   r_b_valid;
    t_op                    r_b_op;
    logic [SAMPLE_BITS:0]   r_b_sum;
    logic                   r_b_row_end;
    logic [OCW:0]           occ;
    logic                   room;
    logic [SAMPLE_BITS+1:0] pair_round;
    logic [SAMPLE_BITS+1:0] block_round;

    // Results in flight plus those queued must leave room for one more.
    always_comb begin
        occ       = {1'b0, i_out_count} + (OCW+1)'(r_b_valid);
        room      = occ < (OCW+1)'(CHS_OUT_DEPTH);
        o_cmd_pop = i_cmd_valid && ((i_cmd_ctl.op == OP_WRITE) || room);
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && (i_cmd_ctl.op == OP_WRITE)) begin
            r_line[i_cmd_slot] <= i_cmd_sum;
        end
        if (o_cmd_pop && (i_cmd_ctl.op == OP_AVG_BLOCK)) begin
            r_rd_data <= r_line[i_cmd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= o_cmd_pop && (i_cmd_ctl.op != OP_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_b_op      <= i_cmd_ctl.op;
            r_b_sum     <= i_cmd_sum;
            r_b_row_end <= i_cmd_ctl.row_end;
        end
    end

    always_comb begin
        pair_round  = {1'b0, r_b_sum} + (SAMPLE_BITS+2)'(1);
        block_round = {1'b0, r_rd_data} + {1'b0, r_b_sum} + (SAMPLE_BITS+2)'(2);
        unique case (r_b_op)
            OP_AVG_BLOCK: o_avg_value = block_round[SAMPLE_BITS+1:2];
            OP_AVG_PAIR:  o_avg_value = pair_round[SAMPLE_BITS:1];
            default:      o_avg_value = pair_round[SAMPLE_BITS:1];
        endcase
        o_res_valid = r_b_valid;
        o_row_end   = r_b_row_end;
    end

endmodule

@@ rtl/chroma_subsampler_unit.sv @@
// Top level of the chroma subsampler: front end, command queue, back end and result queue.
//
//  Channel   Direction  Handshake                 Beat contents
//  --------  ---------  ------------------------  ------------------------------
//  input     in         push / full               i_sample, i_frame_start
//  result    out        empty / pop               o_avg_value, o_row_end
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  The block takes one sample per clock while full is low: the front end handles each
//  beat in the cycle it arrives, and the back end retires one command per cycle, averages
//  only while the result queue has room; commands come at most every other beat, so the
//  sustained rate is one sample per cycle while results drain. Three registers lie between
//  a pair's last beat and the result ports: command queue, line-buffer read, result queue.
//  Reset is synchronous and clears all control state; the line buffer is not cleared and
//  holds unknown data until an even row writes it, so there is no clearing pass.
//  A stalled result side fills the result queue and then the command queue, and only then
//  raises full; configuration writes are always taken.
module chroma_subsampler_unit import chs_pkg::*; #(
    parameter int MAX_LINE_WIDTH = CHS_MAX_LINE_WIDTH,
    parameter int SAMPLE_BITS    = CHS_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [SAMPLE_BITS-1:0]       i_sample,
    input  logic                         i_frame_start,
    output logic                         empty,
    input  logic                         pop,
    output logic [SAMPLE_BITS-1:0]       o_avg_value,
    output logic                         o_row_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [0:0]                   i_cfg_index,
    input  logic [CHS_CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int AW       = $clog2(MAX_LINE_WIDTH / 2);
    localparam int CMD_BITS = CHS_CMD_CTL_BITS + AW + SAMPLE_BITS + 1;
    localparam int OUT_BITS = SAMPLE_BITS + 1;
    localparam int CCW      = $clog2(CHS_CMD_DEPTH);
    localparam int OCW      = $clog2(CHS_OUT_DEPTH);

    // Input side: a beat is taken whenever the command queue has room.
    logic                 in_accept;
    logic                 cmd_push;
    t_cmd_ctl             cmd_ctl_in;
    logic [AW-1:0]        cmd_slot_in;
    logic [SAMPLE_BITS:0] cmd_sum_in;

    // Command queue head as seen by the back end.
    logic [CMD_BITS-1:0]  cmd_data_q;
    logic [CCW:0]         cmd_count;
    logic                 cmd_valid_q;
    logic                 cmd_pop;
    t_cmd_ctl             cmd_ctl_q;
    logic [AW-1:0]        cmd_slot_q;
    logic [SAMPLE_BITS:0] cmd_sum_q;

    // Results from the back end into the result queue.
    logic                   res_valid;
    logic [SAMPLE_BITS-1:0] res_avg;
    logic                   res_row_end;
    logic [OUT_BITS-1:0]    out_data_q;
    logic [OCW:0]           out_count;
    logic                   out_pop;

    assign full      = (cmd_count == (CCW+1)'(CHS_CMD_DEPTH));
    assign in_accept = push && !full;

    chs_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_accept),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .o_cmd_valid   (cmd_push),
        .o_cmd_ctl     (cmd_ctl_in),
        .o_cmd_slot    (cmd_slot_in),
        .o_cmd_sum     (cmd_sum_in)
    );

    chs_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CHS_CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({cmd_ctl_in, cmd_slot_in, cmd_sum_in}),
        .i_pop   (cmd_pop),
        .o_data  (cmd_data_q),
        .o_count (cmd_count)
    );

    assign cmd_valid_q                          = (cmd_count != '0);
    assign {cmd_ctl_q, cmd_slot_q, cmd_sum_q}   = cmd_data_q;

    chs_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid_q),
        .i_cmd_ctl   (cmd_ctl_q),
        .i_cmd_slot  (cmd_slot_q),
        .i_cmd_sum   (cmd_sum_q),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_avg_value (res_avg),
        .o_row_end   (res_row_end)
    );

    // The back end only issues a result when the result queue has a free entry.
    chs_fifo #(
        .WIDTH (OUT_BITS),
        .DEPTH (CHS_OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  ({res_avg, res_row_end}),
        .i_pop   (out_pop),
        .o_data  (out_data_q),
        .o_count (out_count)
    );

    assign empty                    = (out_count == '0);
    assign out_pop                  = pop && !empty;
    assign {o_avg_value, o_row_end} = out_data_q;

endmodule
